// File: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: drum step sequencer shared types and constants
// Payload structs, command and state codes, register indexes, reset values.
// ----------------------------------------------------------------------------
package dss_pkg;

   localparam int NUM_VOICES_DEF = 8;
   localparam int NUM_STEPS_DEF  = 16;
   localparam int MAX_RESULTS    = 8;

   localparam int COUNT_W  = 26;
   localparam int SPS_W    = 24;
   localparam int SWING_W  = 8;
   localparam int VEL_W    = 8;
   localparam int PROD_W   = SPS_W + SWING_W;
   localparam int NRES_W   = 4;
   localparam int MOD_BITS = 26;
   localparam int CELL_W   = VEL_W + 1;

   localparam logic [COUNT_W-1:0] ONE_SAMPLE     = 26'd256;
   localparam logic [SPS_W-1:0]   RESET_SPS      = 24'd1536000;
   localparam logic [SWING_W-1:0] RESET_SWING    = 8'd0;
   localparam logic [VEL_W-1:0]   RESET_VELOCITY = 8'd204;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWING = 1'd1;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_CELL   = 2'd1,
      CMD_PLAY   = 2'd2,
      CMD_LOCATE = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_THR,
      ST_CMP,
      ST_READ,
      ST_CHECK,
      ST_FLUSH,
      ST_MOD,
      ST_REM
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [2:0]  voice;
      logic [3:0]  step_index;
      logic        active;
      logic [7:0]  velocity;
      logic        play;
      logic [31:0] position;
   } req_type;

   typedef struct packed {
      logic [2:0] trig_voice;
      logic [7:0] trig_velocity;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

   typedef struct packed {
      logic busy;
      logic clearing;
   } status_type;

endpackage

// File: rtl/drum_step_sequencer_swing.sv
// Tick: ST_MUL and ST_THR lead to the step compare in ST_CMP; on a step advance
//   each voice is scanned through the pattern RAM port (ST_READ, ST_CHECK), then
//   ST_FLUSH, longer while rsp_stall holds. Cell write and play stay in ST_IDLE.
// Locate: reciprocal multiply (ST_MOD), then one compare/subtract pass (ST_REM).
// Reset: synchronous; a clearing pass then writes all 2^(VW+SW) pattern cells
//   (128 cells at defaults) with req_stall high; CSR writes are taken always.
// ----------------------------------------------------------------------------
// drum_step_sequencer_swing: sample-clocked drum step sequencer with swing
// CSR registers, result output register and the sequencer core.
// ----------------------------------------------------------------------------
module drum_step_sequencer_swing #(
   parameter int NUM_VOICES = dss_pkg::NUM_VOICES_DEF,
   parameter int NUM_STEPS  = dss_pkg::NUM_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dss_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dss_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dss_pkg::SPS_W-1:0]     csr_wdata
);
   import dss_pkg::*;

   logic [SPS_W-1:0]   sps_ff, sps_in;
   logic [SWING_W-1:0] swing_ff, swing_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff, out_data_in;
   logic               out_ready;
   emit_type           emit;
   status_type         status;

   assign csr_ready = 1'b1;
   assign out_ready = !out_valid_ff || !rsp_stall;

   always_comb begin
      sps_in   = sps_ff;
      swing_in = swing_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPS:   sps_in   = csr_wdata;
            CSR_SWING: swing_in = csr_wdata[SWING_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit.valid) begin
         out_valid_in = 1'b1;
         out_data_in  = emit.data;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sps_ff       <= RESET_SPS;
         swing_ff     <= RESET_SWING;
         out_valid_ff <= 1'b0;
      end else begin
         sps_ff       <= sps_in;
         swing_ff     <= swing_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   dss_ctrl #(
      .NUM_VOICES (NUM_VOICES),
      .NUM_STEPS  (NUM_STEPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .sps         (sps_ff),
      .swing       (swing_ff),
      .out_ready   (out_ready),
      .emit        (emit),
      .status      (status)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   a_emit_fits: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_ready)
      else $error("trigger pushed into a held output register");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> req_stall)
      else $error("request taken during pattern clear");

   a_last_ends_tick: assert property (@(posedge clock) disable iff (reset)
      emit.valid && emit.data.last |=> !req_stall && !status.busy)
      else $error("sequencer not idle after final trigger");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> req_stall)
      else $error("request taken while sequencer busy");
endmodule

// File: rtl/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/dss_cmp_sub.sv
// ----------------------------------------------------------------------------
// dss_cmp_sub: shared compare and subtract unit
// Gives a >= b and a - b; used for step thresholds and position reduction.
// ----------------------------------------------------------------------------
module dss_cmp_sub (
   input  logic [dss_pkg::COUNT_W-1:0] op_a,
   input  logic [dss_pkg::COUNT_W-1:0] op_b,
   output logic                        ge,
   output logic [dss_pkg::COUNT_W-1:0] diff
);
   import dss_pkg::*;

   logic [COUNT_W:0] wide_diff;

   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge        = ~wide_diff[COUNT_W];
   assign diff      = wide_diff[COUNT_W-1:0];
endmodule

// File: rtl/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl: sequencer core
// Pattern clear, command decode, swing threshold, step advance, pattern scan, locate.
// ----------------------------------------------------------------------------
module dss_ctrl #(
   parameter int NUM_VOICES = dss_pkg::NUM_VOICES_DEF,
   parameter int NUM_STEPS  = dss_pkg::NUM_STEPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  dss_pkg::req_type            req_payload,
   output logic                        req_stall,
   input  logic [dss_pkg::SPS_W-1:0]   sps,
   input  logic [dss_pkg::SWING_W-1:0] swing,
   input  logic                        out_ready,
   output dss_pkg::emit_type           emit,
   output dss_pkg::status_type         status
);
   import dss_pkg::*;

   localparam int VW      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int SW      = $clog2(NUM_STEPS);
   localparam int AW      = VW + SW;
   localparam int DEPTH   = 1 << AW;
   localparam int RECIP_W = MOD_BITS + 32;
   localparam logic [31:0] MOD_RECIP =
      32'(((64'd1 << 32) + 64'(NUM_STEPS) - 64'd1) / 64'(NUM_STEPS));

   state_type            state_ff, state_in;
   logic                 playing_ff, playing_in;
   logic [SW-1:0]        step_ff, step_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [COUNT_W-1:0]   thr_ff, thr_in;
   logic [VW-1:0]        voice_ff, voice_in;
   logic [NRES_W-1:0]    nres_ff, nres_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [2:0]           pend_voice_ff, pend_voice_in;
   logic [VEL_W-1:0]     pend_vel_ff, pend_vel_in;
   logic [MOD_BITS-1:0]  bits_ff, bits_in;
   logic [MOD_BITS-1:0]  quot_ff, quot_in;
   logic [AW-1:0]        clr_ff, clr_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [CELL_W-1:0]    ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [CELL_W-1:0]    ram_rdata;

   logic [COUNT_W-1:0]   op_a, op_b, cmp_diff;
   logic                 cmp_ge;
   logic [COUNT_W:0]     sum_wide;
   logic [RECIP_W-1:0]   recip_prod;
   logic [COUNT_W-1:0]   quot_steps;
   logic                 take;

   assign ram_raddr  = {step_ff, voice_ff};
   assign sum_wide   = {1'b0, count_ff} + {1'b0, ONE_SAMPLE};
   assign recip_prod = RECIP_W'(bits_ff) * RECIP_W'(MOD_RECIP);
   assign quot_steps = COUNT_W'(quot_ff * MOD_BITS'(NUM_STEPS));
   assign take       = ram_rdata[CELL_W-1] && (nres_ff < NRES_W'(MAX_RESULTS));

   dss_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dss_cmp_sub u_cmp (
      .op_a (op_a),
      .op_b (op_b),
      .ge   (cmp_ge),
      .diff (cmp_diff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         playing_ff    <= 1'b0;
         step_ff       <= '0;
         count_ff      <= '0;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         playing_ff    <= playing_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
      end
      cnt_ff        <= cnt_in;
      prod_ff       <= prod_in;
      thr_ff        <= thr_in;
      voice_ff      <= voice_in;
      nres_ff       <= nres_in;
      pend_voice_ff <= pend_voice_in;
      pend_vel_ff   <= pend_vel_in;
      bits_ff       <= bits_in;
      quot_ff       <= quot_in;
   end

   always_comb begin
      state_in      = state_ff;
      playing_in    = playing_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      thr_in        = thr_ff;
      voice_in      = voice_ff;
      nres_in       = nres_ff;
      pend_valid_in = pend_valid_ff;
      pend_voice_in = pend_voice_ff;
      pend_vel_in   = pend_vel_ff;
      bits_in       = bits_ff;
      quot_in       = quot_ff;
      clr_in        = clr_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_ff;
      ram_wdata     = {1'b0, RESET_VELOCITY};
      op_a          = cnt_ff;
      op_b          = thr_ff;
      emit.valid              = 1'b0;
      emit.data.trig_voice    = pend_voice_ff;
      emit.data.trig_velocity = pend_vel_ff;
      emit.data.last          = (state_ff == ST_FLUSH);
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.cmd)
                  CMD_TICK: begin
                     if (playing_ff) begin
                        state_in = ST_MUL;
                     end
                  end
                  CMD_CELL: begin
                     if ((32'(req_payload.voice) < NUM_VOICES) &&
                         (32'(req_payload.step_index) < NUM_STEPS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = {SW'(req_payload.step_index), VW'(req_payload.voice)};
                        ram_wdata = {req_payload.active, req_payload.velocity};
                     end
                  end
                  CMD_PLAY: begin
                     if (req_payload.play && !playing_ff) begin
                        step_in  = '0;
                        count_in = '0;
                     end
                     playing_in = req_payload.play;
                  end
                  CMD_LOCATE: begin
                     playing_in = req_payload.play;
                     if (req_payload.play) begin
                        bits_in  = req_payload.position[31:6];
                        state_in = ST_MOD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(swing) * PROD_W'(sps);
            cnt_in   = sum_wide[COUNT_W] ? '1 : sum_wide[COUNT_W-1:0];
            state_in = ST_THR;
         end
         ST_THR: begin
            thr_in   = COUNT_W'(sps) + (step_ff[0] ? COUNT_W'(prod_ff[PROD_W-1:9]) : '0);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (cmp_ge) begin
               count_in      = cmp_diff;
               step_in       = (step_ff == SW'(NUM_STEPS - 1)) ? '0 : step_ff + 1'b1;
               voice_in      = '0;
               nres_in       = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_READ;
            end else begin
               count_in = cnt_ff;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (take && pend_valid_ff) begin
               emit.valid = out_ready;
            end
            if (!(take && pend_valid_ff) || out_ready) begin
               if (take) begin
                  pend_valid_in = 1'b1;
                  pend_voice_in = 3'(voice_ff);
                  pend_vel_in   = ram_rdata[VEL_W-1:0];
                  nres_in       = nres_ff + 1'b1;
               end
               if (voice_ff == VW'(NUM_VOICES - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  voice_in = voice_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_ready) begin
               emit.valid    = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_MOD: begin
            quot_in  = recip_prod[RECIP_W-1:32];
            state_in = ST_REM;
         end
         ST_REM: begin
            op_a     = bits_ff;
            op_b     = quot_steps;
            step_in  = cmp_diff[SW-1:0];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign status    = '{busy: (state_ff != ST_IDLE), clearing: (state_ff == ST_CLEAR)};
endmodule
